### rtl/quicksort_lomuto_sorter_macros.svh
// Assertion macros shared by the sorter RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef QUICKSORT_LOMUTO_SORTER_MACROS_SVH
`define QUICKSORT_LOMUTO_SORTER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define QLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define QLS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/qls_pkg.sv
// Package for the quicksort sorter: data width, default capacity and sequencer states.
// Used by qls_store and quicksort_lomuto_sorter; depends on nothing.
package qls_pkg;

  localparam int unsigned QLS_DATA_W       = 32;
  localparam int unsigned QLS_MAX_ELEMENTS = 64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_POP,
    S_POPW,
    S_PIV,
    S_CMP,
    S_SWR,
    S_SWW,
    S_FIN,
    S_FIN2,
    S_PUSH,
    S_EMIT
  } qls_state_e;

endpackage

### rtl/quicksort_lomuto_sorter.sv
// Top level of the quicksort sorter: load, Lomuto partition sequencer, emission.
// Depends on qls_pkg, qls_store and quicksort_lomuto_sorter_macros.svh.
//
// Usage:
// - Input: a word (value_i, is_last_i) is taken at a rising edge with start_i
//   high and busy_o low. Loading takes one word per cycle. Words beyond
//   MAX_ELEMENTS are dropped and the run is marked as overflowed.
// - A word with is_last_i set starts the sort; busy_o stays high until the
//   last result has been issued.
// - Sorting runs on one comparator and an element store with one read and one
//   write port. Each range is popped, its pivot fetched, each word compared
//   with an exchange where needed, the pivot put in place by a final exchange
//   and both sides pushed. Already sorted input is the worst case.
// - Output: n results, one per cycle, each shown for exactly one cycle with
//   result_valid_o high; last_out_o marks the final one and overflow_o is set
//   on every result of an overflowed run. The receiver cannot stall the
//   block; results must be taken as they come.
// - A new load may begin in the cycle the last result is shown.
// - Reset (rst_ni low, asynchronous) empties the store count, the range
//   stack and the overflow flag; store contents are not cleared.
`include "quicksort_lomuto_sorter_macros.svh"

module quicksort_lomuto_sorter import qls_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = QLS_MAX_ELEMENTS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [QLS_DATA_W-1:0] value_i,
  input  logic                         is_last_i,
  output logic                         result_valid_o,
  output logic signed [QLS_DATA_W-1:0] sorted_value_o,
  output logic                         last_out_o,
  output logic                         overflow_o
);

  localparam int unsigned IW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned PW = IW + 1;

  qls_state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] sp_q, sp_d;
  logic [IW-1:0] lo_q, lo_d;
  logic [IW-1:0] hi_q, hi_d;
  logic [IW-1:0] place_q, place_d;
  logic [IW-1:0] j_q, j_d;
  logic [IW-1:0] k_q, k_d;
  logic [QLS_DATA_W-1:0] pivot_q, pivot_d;
  logic [QLS_DATA_W-1:0] elem_q, elem_d;
  logic res_valid_q, res_valid_d;
  logic res_last_q, res_last_d;
  logic res_ovf_q, res_ovf_d;

  // Element store port signals.
  logic                  st_we;
  logic [IW-1:0]         st_waddr;
  logic [QLS_DATA_W-1:0] st_wdata;
  logic [IW-1:0]         st_raddr;
  logic [QLS_DATA_W-1:0] st_rdata;

  // Range stack: {lo, hi} per entry, registered read.
  logic [2*IW-1:0] stk_mem [MAX_ELEMENTS];
  logic [2*IW-1:0] stk_rdata_q;
  logic            stk_we;
  logic [IW-1:0]   stk_waddr;
  logic [2*IW-1:0] stk_wdata;
  logic [IW-1:0]   stk_raddr;

  // Shared datapath terms.
  logic          less;
  logic [IW-1:0] j_next;
  logic [IW-1:0] place_next;
  logic [IW-1:0] place_adv;
  logic [CW-1:0] sp_dec;
  logic [CW-1:0] count_m1;
  logic          stk_room;

  assign less       = $signed(st_rdata) < $signed(pivot_q);
  assign j_next     = j_q + 1'b1;
  assign place_next = place_q + 1'b1;
  assign place_adv  = less ? place_next : place_q;
  assign sp_dec     = sp_q - 1'b1;
  assign count_m1   = count_q - 1'b1;
  assign stk_room   = sp_q < CW'(MAX_ELEMENTS);

  qls_store #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Range stack memory.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  // Sequencer: next state, store and stack accesses, result strobe.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    sp_d        = sp_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    place_d     = place_q;
    j_d         = j_q;
    k_d         = k_q;
    pivot_d     = pivot_q;
    elem_d      = elem_q;
    res_valid_d = 1'b0;
    res_last_d  = 1'b0;
    res_ovf_d   = ovf_q;
    st_we       = 1'b0;
    st_waddr    = j_q;
    st_wdata    = st_rdata;
    st_raddr    = j_q;
    stk_we      = 1'b0;
    stk_waddr   = sp_q[IW-1:0];
    stk_wdata   = {lo_q, hi_q};
    stk_raddr   = sp_dec[IW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (count_q < CW'(MAX_ELEMENTS)) begin
            st_we    = 1'b1;
            st_waddr = count_q[IW-1:0];
            st_wdata = value_i;
            count_d  = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (is_last_i) begin
            state_d = S_INIT;
          end
        end
      end

      // Push the whole store as the first range when it holds two or more words.
      S_INIT: begin
        sp_d = '0;
        k_d  = '0;
        if (count_q > CW'(1)) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = {{IW{1'b0}}, count_m1[IW-1:0]};
          sp_d      = CW'(1);
          state_d   = S_POP;
        end else begin
          state_d = S_EMIT;
        end
      end

      S_POP: begin
        if (sp_q == '0) begin
          k_d     = '0;
          state_d = S_EMIT;
        end else begin
          sp_d    = sp_dec;
          state_d = S_POPW;
        end
      end

      // Range bounds are back from the stack; fetch the pivot.
      S_POPW: begin
        lo_d     = stk_rdata_q[2*IW-1:IW];
        hi_d     = stk_rdata_q[IW-1:0];
        st_raddr = stk_rdata_q[IW-1:0];
        if ((stk_rdata_q[2*IW-1:IW] >= stk_rdata_q[IW-1:0]) ||
            (CW'(stk_rdata_q[IW-1:0]) >= count_q)) begin
          state_d = S_POP;
        end else begin
          state_d = S_PIV;
        end
      end

      S_PIV: begin
        pivot_d  = st_rdata;
        place_d  = lo_q;
        j_d      = lo_q;
        st_raddr = lo_q;
        state_d  = S_CMP;
      end

      // Compare store[j] with the pivot; start an exchange when needed.
      S_CMP: begin
        elem_d = st_rdata;
        if (less && (place_q != j_q)) begin
          st_raddr = place_q;
          state_d  = S_SWR;
        end else begin
          place_d = place_adv;
          j_d     = j_next;
          if (j_next == hi_q) begin
            st_raddr = place_adv;
            state_d  = S_FIN;
          end else begin
            st_raddr = j_next;
          end
        end
      end

      // First half of the exchange: store[place] goes to j.
      S_SWR: begin
        st_we    = 1'b1;
        st_waddr = j_q;
        st_wdata = st_rdata;
        state_d  = S_SWW;
      end

      // Second half: the old store[j] goes to place, then move on.
      S_SWW: begin
        st_we    = 1'b1;
        st_waddr = place_q;
        st_wdata = elem_q;
        place_d  = place_next;
        j_d      = j_next;
        if (j_next == hi_q) begin
          st_raddr = place_next;
          state_d  = S_FIN;
        end else begin
          st_raddr = j_next;
          state_d  = S_CMP;
        end
      end

      // Final exchange of place and hi puts the pivot in its slot.
      S_FIN: begin
        st_we    = 1'b1;
        st_waddr = hi_q;
        st_wdata = st_rdata;
        state_d  = S_FIN2;
      end

      S_FIN2: begin
        st_we    = 1'b1;
        st_waddr = place_q;
        st_wdata = pivot_q;
        if ((PW'(place_q) > (PW'(lo_q) + PW'(1))) && stk_room) begin
          stk_we    = 1'b1;
          stk_wdata = {lo_q, place_q - 1'b1};
          sp_d      = sp_q + 1'b1;
        end
        state_d = S_PUSH;
      end

      S_PUSH: begin
        if (((PW'(place_q) + PW'(1)) < PW'(hi_q)) && stk_room) begin
          stk_we    = 1'b1;
          stk_wdata = {place_next, hi_q};
          sp_d      = sp_q + 1'b1;
        end
        state_d = S_POP;
      end

      // Read out one word per cycle; the strobe is registered and comes with the data in the cycle after the read.
      S_EMIT: begin
        st_raddr    = k_q;
        res_valid_d = 1'b1;
        k_d         = k_q + 1'b1;
        if ((CW'(k_q) + CW'(1)) == count_q) begin
          res_last_d = 1'b1;
          count_d    = '0;
          ovf_d      = 1'b0;
          sp_d       = '0;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      sp_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      sp_q        <= sp_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Working registers of the partition and result flags.
  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    place_q    <= place_d;
    j_q        <= j_d;
    k_q        <= k_d;
    pivot_q    <= pivot_d;
    elem_q     <= elem_d;
    res_last_q <= res_last_d;
    res_ovf_q  <= res_ovf_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign sorted_value_o = st_rdata;
  assign last_out_o     = res_last_q;
  assign overflow_o     = res_ovf_q;

  // Checks on the sequencer.
  `QLS_ASSERT(a_mid_result_busy, (result_valid_o && !last_out_o) |-> busy_o, "result before end while idle")
  `QLS_ASSERT(a_last_starts_sort, (start_i && !busy_o && is_last_i) |=> busy_o, "last word did not start sort")
  `QLS_ASSERT(a_single_last, last_out_o |=> !result_valid_o, "result after last word")
  `QLS_ASSERT_NEVER(a_count_range, count_q > CW'(MAX_ELEMENTS), "element count beyond capacity")

endmodule

### rtl/qls_store.sv
// Element store of the sorter: one write port and one registered read port.
// Depends on qls_pkg for the data width.
module qls_store import qls_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = QLS_MAX_ELEMENTS,
  localparam int unsigned IW = $clog2(MAX_ELEMENTS)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IW-1:0]         waddr_i,
  input  logic [QLS_DATA_W-1:0] wdata_i,
  input  logic [IW-1:0]         raddr_i,
  output logic [QLS_DATA_W-1:0] rdata_o
);

  logic [QLS_DATA_W-1:0] mem [MAX_ELEMENTS];
  logic [QLS_DATA_W-1:0] rdata_q;

  // Write port and registered read port; a same-address read returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
